// ===== rtl/rfr_pkg.sv =====
// Package: shared types, constants and the CRC16 byte update for the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package rfr_pkg;

   localparam int unsigned MAX_PAYLOAD    = 32;
   localparam int unsigned FRAME_OVERHEAD = 8;
   localparam int unsigned HEADER_LEN     = 6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Configuration register indexes
   localparam logic [1:0] CSR_START_A = 2'd0;
   localparam logic [1:0] CSR_START_B = 2'd1;
   localparam logic [1:0] CSR_START_C = 2'd2;
   localparam logic [1:0] CSR_START_D = 2'd3;

   localparam logic [7:0] START_A_RESET = 8'h7E;
   localparam logic [7:0] START_B_RESET = 8'hF6;
   localparam logic [7:0] START_C_RESET = 8'hF7;
   localparam logic [7:0] START_D_RESET = 8'h52;

   typedef enum logic [1:0] {
      RSP_PROGRESS = 2'd0,
      RSP_GOOD     = 2'd1,
      RSP_BAD_LEN  = 2'd2,
      RSP_CRC_BAD  = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_BODY
   } phase_type;

   typedef enum logic [1:0] {
      OUT_EMPTY,
      OUT_STATUS,
      OUT_RUN
   } out_state_type;

   typedef struct packed {
      logic           clear;
      logic           load_start;
      logic           hdr_byte;
      logic           info_byte;
      logic           low_byte;
      logic           out_status;
      logic           out_run_first;
      logic           out_run_next;
      rsp_status_type status_code;
   } dp_cmd_type;

   typedef struct packed {
      logic start_hit;
      logic header_full;
      logic len_bad;
      logic info_byte;
      logic low_byte;
      logic crc_ok;
      logic rsp_last;
   } dp_status_type;

   // Reflected CRC16, one byte: eight shift steps
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rs485_frame_receiver_core.sv =====
// Top level: byte-serial frame receiver with start-byte hunt and Modbus CRC16 check.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Beat carries
// req      in         req_valid / req_ready  one received line byte
// rsp      out        rsp_valid / rsp_ready  status, header, one info byte, crc, last
// csr      in         csr_valid / csr_ready  start byte register index and value
//
// Each accepted byte is parsed and its CRC folded in the same cycle; its result
// sits in the output register on the next cycle. A new byte is taken while the
// final beat of the previous result is being taken, so bytes flow at one per
// cycle when rsp_ready stays high. A good frame holds off input until the last
// beat of its run, one per info byte, has been taken from the info store.
// Reset (synchronous) restores the default start bytes and returns to hunting.
// A stalled result holds all its fields; csr writes are always taken.

module rs485_frame_receiver_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_frame_start,
   output logic [7:0]       rsp_dest_addr,
   output logic [7:0]       rsp_src_addr,
   output logic [7:0]       rsp_command,
   output logic [7:0]       rsp_sub_command,
   output logic [5:0]       rsp_payload_len,
   output logic [7:0]       rsp_payload_byte,
   output logic [4:0]       rsp_payload_pos,
   output logic [15:0]      rsp_crc_value,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   rfr_pkg::dp_cmd_type    cmd;
   rfr_pkg::dp_status_type status;

   // Start byte registers accept a write on any cycle
   assign csr_ready = 1'b1;

   rfr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rfr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rx_byte          (req_rx_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_status       (rsp_status),
      .rsp_frame_start  (rsp_frame_start),
      .rsp_dest_addr    (rsp_dest_addr),
      .rsp_src_addr     (rsp_src_addr),
      .rsp_command      (rsp_command),
      .rsp_sub_command  (rsp_sub_command),
      .rsp_payload_len  (rsp_payload_len),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_pos  (rsp_payload_pos),
      .rsp_crc_value    (rsp_crc_value),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/rfr_datapath.sv =====
// Datapath: start byte registers, header and info stores, CRC and result registers.
`timescale 1ns / 1ps
`default_nettype none

module rfr_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [1:0]            csr_index,
   input  wire logic [7:0]            csr_data,
   input  wire logic [7:0]            rx_byte,
   input  wire rfr_pkg::dp_cmd_type   cmd,
   output rfr_pkg::dp_status_type     status,
   output logic [1:0]                 rsp_status,
   output logic [7:0]                 rsp_frame_start,
   output logic [7:0]                 rsp_dest_addr,
   output logic [7:0]                 rsp_src_addr,
   output logic [7:0]                 rsp_command,
   output logic [7:0]                 rsp_sub_command,
   output logic [5:0]                 rsp_payload_len,
   output logic [7:0]                 rsp_payload_byte,
   output logic [4:0]                 rsp_payload_pos,
   output logic [15:0]                rsp_crc_value,
   output logic                       rsp_last
);

   logic [7:0]  start_a_ff, start_b_ff, start_c_ff, start_d_ff;
   logic [5:0]  count_ff, count_in;
   logic [5:0]  total_ff, total_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  low_ff, low_in;
   logic [7:0]  header_ff [rfr_pkg::HEADER_LEN];
   logic [7:0]  store_ff [rfr_pkg::MAX_PAYLOAD];
   logic [5:0]  run_idx_ff;

   logic [1:0]  status_ff;
   logic [7:0]  start_out_ff, dest_ff, src_ff, command_ff, sub_ff;
   logic [5:0]  len_out_ff;
   logic [7:0]  byte_out_ff;
   logic [4:0]  pos_out_ff;
   logic [15:0] crc_out_ff;
   logic        last_ff;

   logic [5:0]  len6;
   logic [5:0]  info_pos;
   logic [5:0]  count_inc;
   logic [15:0] crc_byte;
   logic [15:0] rx_crc;

   assign len6      = header_ff[5][5:0];
   assign info_pos  = count_ff - 6'(rfr_pkg::HEADER_LEN);
   assign count_inc = count_ff + 6'd1;
   assign crc_byte  = rfr_pkg::crc16_update(crc_ff, rx_byte);
   assign rx_crc    = {rx_byte, low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         start_a_ff <= rfr_pkg::START_A_RESET;
         start_b_ff <= rfr_pkg::START_B_RESET;
         start_c_ff <= rfr_pkg::START_C_RESET;
         start_d_ff <= rfr_pkg::START_D_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            rfr_pkg::CSR_START_A: start_a_ff <= csr_data;
            rfr_pkg::CSR_START_B: start_b_ff <= csr_data;
            rfr_pkg::CSR_START_C: start_c_ff <= csr_data;
            rfr_pkg::CSR_START_D: start_d_ff <= csr_data;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      crc_in   = crc_ff;
      low_in   = low_ff;
      if (cmd.hdr_byte) begin
         count_in = count_inc;
         crc_in   = crc_byte;
         if (status.header_full) begin
            total_in = rx_byte[5:0] + 6'(rfr_pkg::FRAME_OVERHEAD);
         end
      end
      if (cmd.info_byte) begin
         count_in = count_inc;
         crc_in   = crc_byte;
      end
      if (cmd.low_byte) begin
         count_in = count_inc;
         low_in   = rx_byte;
      end
      if (cmd.clear) begin
         count_in = '0;
         total_in = '0;
         crc_in   = rfr_pkg::CRC_INIT;
         low_in   = '0;
      end
      if (cmd.load_start) begin
         count_in = 6'd1;
         crc_in   = rfr_pkg::crc16_update(rfr_pkg::CRC_INIT, rx_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         crc_ff   <= rfr_pkg::CRC_INIT;
         low_ff   <= '0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         crc_ff   <= crc_in;
         low_ff   <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         header_ff[0] <= rx_byte;
      end else if (cmd.hdr_byte) begin
         header_ff[count_ff[2:0]] <= rx_byte;
      end
      if (cmd.info_byte) begin
         store_ff[info_pos[4:0]] <= rx_byte;
      end
   end

   always_comb begin
      status.start_hit   = (rx_byte == start_a_ff) || (rx_byte == start_b_ff) ||
                           (rx_byte == start_c_ff) || (rx_byte == start_d_ff);
      status.header_full = (count_ff == 6'(rfr_pkg::HEADER_LEN - 1));
      status.len_bad     = (rx_byte > 8'(rfr_pkg::MAX_PAYLOAD));
      status.info_byte   = (count_ff < 6'(rfr_pkg::HEADER_LEN) + len6);
      status.low_byte    = (count_inc < total_ff);
      status.crc_ok      = (rx_crc == crc_ff);
      status.rsp_last    = last_ff;
   end

   // Result register: set by a status or first run beat, stepped by later run beats
   always_ff @(posedge clock) begin
      if (cmd.out_status) begin
         status_ff    <= cmd.status_code;
         start_out_ff <= '0;
         dest_ff      <= '0;
         src_ff       <= '0;
         command_ff   <= '0;
         sub_ff       <= '0;
         len_out_ff   <= '0;
         byte_out_ff  <= '0;
         pos_out_ff   <= '0;
         crc_out_ff   <= '0;
         last_ff      <= 1'b1;
      end else if (cmd.out_run_first) begin
         status_ff    <= rfr_pkg::RSP_GOOD;
         start_out_ff <= header_ff[0];
         dest_ff      <= header_ff[1];
         src_ff       <= header_ff[2];
         command_ff   <= header_ff[3];
         sub_ff       <= header_ff[4];
         len_out_ff   <= len6;
         byte_out_ff  <= (len6 != '0) ? store_ff[0] : 8'h00;
         pos_out_ff   <= '0;
         crc_out_ff   <= rx_crc;
         last_ff      <= (len6 <= 6'd1);
         run_idx_ff   <= 6'd1;
      end else if (cmd.out_run_next) begin
         byte_out_ff  <= store_ff[run_idx_ff[4:0]];
         pos_out_ff   <= run_idx_ff[4:0];
         last_ff      <= (run_idx_ff + 6'd1 == len_out_ff);
         run_idx_ff   <= run_idx_ff + 6'd1;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_frame_start  = start_out_ff;
   assign rsp_dest_addr    = dest_ff;
   assign rsp_src_addr     = src_ff;
   assign rsp_command      = command_ff;
   assign rsp_sub_command  = sub_ff;
   assign rsp_payload_len  = len_out_ff;
   assign rsp_payload_byte = byte_out_ff;
   assign rsp_payload_pos  = pos_out_ff;
   assign rsp_crc_value    = crc_out_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

// ===== rtl/rfr_controller.sv =====
// Controller: parse phase state machine and result handshake sequencing.
`timescale 1ns / 1ps
`default_nettype none

module rfr_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rfr_pkg::dp_status_type status,
   output rfr_pkg::dp_cmd_type         cmd
);

   rfr_pkg::phase_type     phase_ff, phase_in;
   rfr_pkg::out_state_type out_ff, out_in;
   logic                   take;
   logic                   drain;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rfr_pkg::PH_HUNT;
         out_ff   <= rfr_pkg::OUT_EMPTY;
      end else begin
         phase_ff <= phase_in;
         out_ff   <= out_in;
      end
   end

   always_comb begin
      rsp_valid = (out_ff != rfr_pkg::OUT_EMPTY);
      drain     = rsp_valid && rsp_ready;
      req_ready = !rsp_valid || (rsp_ready && status.rsp_last);
      take      = req_valid && req_ready;

      cmd             = '0;
      cmd.status_code = rfr_pkg::RSP_PROGRESS;
      phase_in        = phase_ff;
      out_in          = out_ff;

      if (drain) begin
         if (status.rsp_last) begin
            out_in = rfr_pkg::OUT_EMPTY;
         end else begin
            cmd.out_run_next = 1'b1;
         end
      end

      if (take) begin
         out_in         = rfr_pkg::OUT_STATUS;
         cmd.out_status = 1'b1;
         unique case (phase_ff)
            rfr_pkg::PH_HEADER: begin
               cmd.hdr_byte = 1'b1;
               if (status.header_full) begin
                  if (status.len_bad) begin
                     cmd.clear       = 1'b1;
                     cmd.status_code = rfr_pkg::RSP_BAD_LEN;
                     phase_in        = rfr_pkg::PH_HUNT;
                  end else begin
                     phase_in = rfr_pkg::PH_BODY;
                  end
               end
            end
            rfr_pkg::PH_BODY: begin
               priority if (status.info_byte) begin
                  cmd.info_byte = 1'b1;
               end else if (status.low_byte) begin
                  cmd.low_byte = 1'b1;
               end else if (status.crc_ok) begin
                  cmd.clear         = 1'b1;
                  cmd.out_status    = 1'b0;
                  cmd.out_run_first = 1'b1;
                  out_in            = rfr_pkg::OUT_RUN;
                  phase_in          = rfr_pkg::PH_HUNT;
               end else begin
                  cmd.clear       = 1'b1;
                  cmd.status_code = rfr_pkg::RSP_CRC_BAD;
                  phase_in        = rfr_pkg::PH_HUNT;
               end
            end
            default: begin
               // hunting: restart the parser on every byte, arm on a start byte
               cmd.clear = 1'b1;
               phase_in  = rfr_pkg::PH_HUNT;
               if (status.start_hit) begin
                  cmd.load_start = 1'b1;
                  phase_in       = rfr_pkg::PH_HEADER;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== verif/rs485_frame_receiver_core_test.sv =====
// Testbench for the frame receiver core: byte stimulus, scoreboard and pass/fail report.
`timescale 1ns / 1ps

module rs485_frame_receiver_core_test;

   localparam int RUN_CAP     = 32;
   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE      = 4;

   localparam logic [1:0] START_REGS [4] = '{rfr_pkg::CSR_START_A, rfr_pkg::CSR_START_B,
                                             rfr_pkg::CSR_START_C, rfr_pkg::CSR_START_D};

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  frame_start;
      logic [7:0]  dest_addr;
      logic [7:0]  src_addr;
      logic [7:0]  command;
      logic [7:0]  sub_command;
      logic [5:0]  payload_len;
      logic [7:0]  payload_byte;
      logic [4:0]  payload_pos;
      logic [15:0] crc_value;
      logic        last;
   } rsp_beat_type;

   // Frame parser mirror plus the queue of result beats still owed by the block.
   class frame_scoreboard;
      rsp_beat_type       pending[$];
      logic [7:0]         start_reg [4];
      rfr_pkg::phase_type phase;
      logic [5:0]         byte_count;
      logic [5:0]         frame_total;
      logic [7:0]         header_bytes [rfr_pkg::HEADER_LEN];
      logic [15:0]        running_crc;
      logic [7:0]         crc_low_byte;
      logic [7:0]         payload_store [rfr_pkg::MAX_PAYLOAD];
      int                 errors;

      function new();
         start_reg[rfr_pkg::CSR_START_A] = rfr_pkg::START_A_RESET;
         start_reg[rfr_pkg::CSR_START_B] = rfr_pkg::START_B_RESET;
         start_reg[rfr_pkg::CSR_START_C] = rfr_pkg::START_C_RESET;
         start_reg[rfr_pkg::CSR_START_D] = rfr_pkg::START_D_RESET;
         errors = 0;
         foreach (header_bytes[i]) header_bytes[i] = '0;
         foreach (payload_store[i]) payload_store[i] = '0;
         clear();
      endfunction

      static function logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc ^ {8'h00, b};
         repeat (8) c = c[0] ? ((c >> 1) ^ rfr_pkg::CRC_POLY) : (c >> 1);
         return c;
      endfunction

      function void clear();
         phase        = rfr_pkg::PH_HUNT;
         byte_count   = '0;
         frame_total  = '0;
         running_crc  = rfr_pkg::CRC_INIT;
         crc_low_byte = '0;
      endfunction

      function void push_status(rfr_pkg::rsp_status_type s);
         rsp_beat_type beat;
         beat        = '0;
         beat.status = s;
         beat.last   = 1'b1;
         pending.push_back(beat);
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] value);
         start_reg[idx] = value;
      endfunction

      // Advance the parser by one accepted byte and queue the beats it owes.
      function void note_byte(logic [7:0] b);
         rsp_beat_type beat;
         logic [5:0]   pos;
         logic [7:0]   plen;
         logic [15:0]  rx_crc;
         int           n;
         int           i;
         plen = header_bytes[5];
         unique case (phase)
            rfr_pkg::PH_HEADER: begin
               if (byte_count < rfr_pkg::HEADER_LEN) header_bytes[byte_count[2:0]] = b;
               running_crc = crc_fold(running_crc, b);
               byte_count++;
               if (byte_count >= rfr_pkg::HEADER_LEN) begin
                  if (header_bytes[5] > rfr_pkg::MAX_PAYLOAD) begin
                     clear();
                     push_status(rfr_pkg::RSP_BAD_LEN);
                     return;
                  end
                  frame_total = 6'(header_bytes[5] + rfr_pkg::FRAME_OVERHEAD);
                  phase = rfr_pkg::PH_BODY;
               end
               push_status(rfr_pkg::RSP_PROGRESS);
            end
            rfr_pkg::PH_BODY: begin
               pos = byte_count;
               byte_count++;
               if (pos < rfr_pkg::HEADER_LEN + plen) begin
                  payload_store[5'(pos - rfr_pkg::HEADER_LEN)] = b;
                  running_crc = crc_fold(running_crc, b);
                  push_status(rfr_pkg::RSP_PROGRESS);
               end else if (byte_count < frame_total) begin
                  crc_low_byte = b;
                  push_status(rfr_pkg::RSP_PROGRESS);
               end else begin
                  rx_crc = {b, crc_low_byte};
                  if (rx_crc != running_crc) begin
                     clear();
                     push_status(rfr_pkg::RSP_CRC_BAD);
                  end else begin
                     // an empty frame still gives one beat
                     n = (plen == 0) ? 1 : plen;
                     if (n > RUN_CAP) n = RUN_CAP;
                     for (i = 0; i < n; i++) begin
                        beat.status       = rfr_pkg::RSP_GOOD;
                        beat.frame_start  = header_bytes[0];
                        beat.dest_addr    = header_bytes[1];
                        beat.src_addr     = header_bytes[2];
                        beat.command      = header_bytes[3];
                        beat.sub_command  = header_bytes[4];
                        beat.payload_len  = plen[5:0];
                        beat.payload_byte = (plen > 0) ? payload_store[5'(i)] : 8'h00;
                        beat.payload_pos  = (plen > 0) ? 5'(i) : 5'd0;
                        beat.crc_value    = rx_crc;
                        beat.last         = (i == n - 1);
                        pending.push_back(beat);
                     end
                     clear();
                  end
               end
            end
            default: begin
               clear();
               if (b == start_reg[0] || b == start_reg[1] ||
                   b == start_reg[2] || b == start_reg[3]) begin
                  header_bytes[0] = b;
                  running_crc     = crc_fold(rfr_pkg::CRC_INIT, b);
                  byte_count      = 6'd1;
                  phase           = rfr_pkg::PH_HEADER;
               end
               push_status(rfr_pkg::RSP_PROGRESS);
            end
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
         end
      endfunction

      function void check_beat(rsp_beat_type got);
         rsp_beat_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: beat with nothing expected, status %h", $time, got.status);
            return;
         end
         want = pending.pop_front();
         compare_field("status",       16'(want.status),       16'(got.status));
         compare_field("frame_start",  16'(want.frame_start),  16'(got.frame_start));
         compare_field("dest_addr",    16'(want.dest_addr),    16'(got.dest_addr));
         compare_field("src_addr",     16'(want.src_addr),     16'(got.src_addr));
         compare_field("command",      16'(want.command),      16'(got.command));
         compare_field("sub_command",  16'(want.sub_command),  16'(got.sub_command));
         compare_field("payload_len",  16'(want.payload_len),  16'(got.payload_len));
         compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
         compare_field("payload_pos",  16'(want.payload_pos),  16'(got.payload_pos));
         compare_field("crc_value",    want.crc_value,         got.crc_value);
         compare_field("last",         16'(want.last),         16'(got.last));
      endfunction
   endclass

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_frame_start;
   logic [7:0]  rsp_dest_addr;
   logic [7:0]  rsp_src_addr;
   logic [7:0]  rsp_command;
   logic [7:0]  rsp_sub_command;
   logic [5:0]  rsp_payload_len;
   logic [7:0]  rsp_payload_byte;
   logic [4:0]  rsp_payload_pos;
   logic [15:0] rsp_crc_value;
   logic        rsp_last;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index   = rfr_pkg::CSR_START_A;
   logic [7:0]  csr_data    = 8'h00;

   frame_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent    = 0;
   int quiet_cycles  = 0;

   rs485_frame_receiver_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_frame_start  (rsp_frame_start),
      .rsp_dest_addr    (rsp_dest_addr),
      .rsp_src_addr     (rsp_src_addr),
      .rsp_command      (rsp_command),
      .rsp_sub_command  (rsp_sub_command),
      .rsp_payload_len  (rsp_payload_len),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_pos  (rsp_payload_pos),
      .rsp_crc_value    (rsp_crc_value),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver side: drop ready at random for the current idle share.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Observe every handshake at the edge; results first, then new bytes.
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (rsp_valid === 1'b1 && rsp_ready) begin
            sb.check_beat({rsp_status, rsp_frame_start, rsp_dest_addr, rsp_src_addr,
                           rsp_command, rsp_sub_command, rsp_payload_len,
                           rsp_payload_byte, rsp_payload_pos, rsp_crc_value, rsp_last});
            quiet_cycles = 0;
         end
         if (req_valid && req_ready === 1'b1) begin
            sb.note_byte(req_rx_byte);
            quiet_cycles = 0;
         end
         if (csr_valid && csr_ready === 1'b1) begin
            sb.write_reg(csr_index, csr_data);
            quiet_cycles = 0;
         end
      end
   end

   // Watchdog: end the run if no beat moves on any channel for too long.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Offer one byte; hold valid and data until the beat is taken.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
      bytes_sent++;
   endtask

   // Stop sending and hold until every owed beat has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the last accepted byte reach the scoreboard first
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write all four start byte registers back to back; parser must be idle.
   task automatic load_start_bytes(input logic [3:0][7:0] vals);
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= START_REGS[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Build a frame with random header and info; a length above the store
   // size stops after the length byte, since the parser drops it there.
   task automatic send_frame(input logic [7:0] sof, input logic [7:0] plen,
                             input bit spoil_crc);
      logic [7:0]  line[$];
      logic [15:0] crc;
      line = {sof, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), plen};
      if (plen <= rfr_pkg::MAX_PAYLOAD) begin
         repeat (plen) line.push_back(8'($urandom));
         crc = rfr_pkg::CRC_INIT;
         foreach (line[i]) crc = frame_scoreboard::crc_fold(crc, line[i]);
         if (spoil_crc) crc ^= 16'(1) << $urandom_range(15);
         line.push_back(crc[7:0]);
         line.push_back(crc[15:8]);
      end
      foreach (line[i]) send_byte(line[i]);
   endtask

   // Mostly well-formed frames with random content, some broken ones and noise.
   task automatic random_traffic(input int budget, input bit with_full_frame);
      int         target;
      int         pick;
      logic [7:0] sof;
      logic [7:0] plen;
      target = bytes_sent + budget;
      if (with_full_frame) begin
         send_frame(sb.start_reg[$urandom_range(3)], 8'(rfr_pkg::MAX_PAYLOAD), 1'b0);
      end
      while (bytes_sent < target) begin
         pick = $urandom_range(99);
         sof  = sb.start_reg[$urandom_range(3)];
         plen = ($urandom_range(11) == 0) ? 8'($urandom_range(rfr_pkg::MAX_PAYLOAD))
                                          : 8'($urandom_range(5));
         if (pick < 68) begin
            send_frame(sof, plen, 1'b0);
         end else if (pick < 80) begin
            send_frame(sof, 8'($urandom_range(255, rfr_pkg::MAX_PAYLOAD + 1)), 1'b0);
         end else if (pick < 92) begin
            send_frame(sof, plen, 1'b1);
         end else begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
         end
         if ($urandom_range(5) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      send_idle_pct = 22;
      recv_idle_pct = 88;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: line extremes in the hunt, an empty good frame, a length one
      // past the store size, and a frame with a broken CRC.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(rfr_pkg::START_A_RESET, 8'd0, 1'b0);
      send_frame(rfr_pkg::START_D_RESET, 8'(rfr_pkg::MAX_PAYLOAD + 1), 1'b0);
      send_frame(rfr_pkg::START_B_RESET, 8'd1, 1'b1);
      wait_drained();

      random_traffic(15, 1'b0);

      send_idle_pct = 88;
      recv_idle_pct = 22;
      load_start_bytes({8'($urandom), 8'($urandom), 8'hFF, 8'h00});
      random_traffic(15, 1'b1);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_start_bytes({8'h01, 8'h80, 8'($urandom), 8'($urandom)});
      random_traffic(15, 1'b0);

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, sb.pending.size());
      end
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rfr_pkg.sv
rtl/rfr_datapath.sv
rtl/rfr_controller.sv
rtl/rs485_frame_receiver_core.sv
verif/rs485_frame_receiver_core_test.sv
